// ----- hw/rtl/ucd_pkg.sv -----
// Shared types, constants and the month table of the Unix time to civil date converter.
`default_nettype none

package ucd_pkg;

    // register stages from input to output
    localparam int unsigned NUM_STAGES = 6;

    typedef logic [NUM_STAGES-1:0] stage_vec_t;

    // secs / 86400 is (secs >> 7) / 675, done as an exact reciprocal multiply
    localparam int unsigned DAY_POW2_SHIFT = 7;
    localparam logic [25:0] DAY_RECIP      = 26'd50903317;
    localparam int unsigned DAY_RECIP_SHR  = 35;
    localparam logic [9:0]  DAY_ODD_FACTOR = 10'd675;

    typedef logic [15:0] day_num_t;

    // first day of each March-based month in the March-based year: (153 * mon + 2) / 5
    function automatic logic [8:0] month_start(input logic [3:0] mon);
        logic [8:0] start;
        begin
            case (mon)
                4'd0:    start = 9'd0;
                4'd1:    start = 9'd31;
                4'd2:    start = 9'd61;
                4'd3:    start = 9'd92;
                4'd4:    start = 9'd122;
                4'd5:    start = 9'd153;
                4'd6:    start = 9'd184;
                4'd7:    start = 9'd214;
                4'd8:    start = 9'd245;
                4'd9:    start = 9'd275;
                4'd10:   start = 9'd306;
                4'd11:   start = 9'd337;
                default: start = 9'd0;
            endcase
            return start;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ucd_date_path.sv -----
// Date pipeline: whole days since 1970 to Gregorian year, month and day.
`default_nettype none

module ucd_date_path
(
    input  wire logic                clk,
    input  wire ucd_pkg::stage_vec_t en,
    input  wire ucd_pkg::day_num_t   day_num,
    output logic [11:0]              year,
    output logic [3:0]               month,
    output logic [4:0]               day
);

    // day counts since 1970 at which the March-based centuries 2000 and 2100 begin
    localparam logic [15:0] C20_START = 16'd11017;
    localparam logic [15:0] C21_START = 16'd47541;
    // offset from days since 1970 to day of the century starting 1900-03-01
    localparam logic [15:0] C19_OFFSET = 16'd25508;

    // stage 1
    logic [15:0] doc1_reg, doc1_next;
    logic [11:0] yrb1_reg, yrb1_next;
    // stage 2
    logic [15:0] doc2_reg;
    logic [11:0] yrb2_reg;
    logic [6:0]  yoc2_reg, yoc2_next;
    // stage 3
    logic [8:0]  doy3_reg, doy3_next;
    logic [11:0] year3_reg, year3_next;
    // stage 4
    logic [8:0]  doy4_reg;
    logic [11:0] year4_reg;
    logic [3:0]  mon4_reg, mon4_next;
    // stage 5
    logic [11:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;

    logic [17:0] yr_n;
    logic [35:0] yr_prod;
    logic [15:0] yr_days;
    logic [15:0] doy_wide;
    logic [10:0] mon_n;
    logic [21:0] mon_prod;
    logic        wrap;
    logic [8:0]  day_wide;

    // pick the century by comparing against its first day
    always_comb
    begin
        if (day_num >= C21_START)
        begin
            doc1_next = day_num - C21_START;
            yrb1_next = 12'd2100;
        end
        else if (day_num >= C20_START)
        begin
            doc1_next = day_num - C20_START;
            yrb1_next = 12'd2000;
        end
        else
        begin
            doc1_next = day_num + C19_OFFSET;
            yrb1_next = 12'd1900;
        end
    end

    // year of century: 4 * (doc + 366) / 1461 - 1 by exact reciprocal
    assign yr_n      = {doc1_reg + 16'd366, 2'b00};
    assign yr_prod   = {18'd0, yr_n} * 36'd183735;
    assign yoc2_next = yr_prod[34:28] - 7'd1;

    assign yr_days    = ({9'd0, yoc2_reg} * 16'd365) + {11'd0, yoc2_reg[6:2]};
    assign doy_wide   = doc2_reg - yr_days;
    assign doy3_next  = doy_wide[8:0];
    assign year3_next = yrb2_reg + {5'd0, yoc2_reg};

    // March-based month: (5 * doy + 2) / 153 by exact reciprocal
    assign mon_n     = {doy3_reg, 2'b00} + {2'b00, doy3_reg} + 11'd2;
    assign mon_prod  = {11'd0, mon_n} * 22'd1714;
    assign mon4_next = mon_prod[21:18];

    // January and February belong to the next calendar year
    assign wrap       = (mon4_reg >= 4'd10);
    assign month_next = wrap ? (mon4_reg - 4'd9) : (mon4_reg + 4'd3);
    assign year_next  = year4_reg + {11'd0, wrap};
    assign day_wide   = doy4_reg - ucd_pkg::month_start(mon4_reg) + 9'd1;
    assign day_next   = day_wide[4:0];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            doc1_reg <= doc1_next;
            yrb1_reg <= yrb1_next;
        end
        if (en[2])
        begin
            doc2_reg <= doc1_reg;
            yrb2_reg <= yrb1_reg;
            yoc2_reg <= yoc2_next;
        end
        if (en[3])
        begin
            doy3_reg  <= doy3_next;
            year3_reg <= year3_next;
        end
        if (en[4])
        begin
            doy4_reg  <= doy3_reg;
            year4_reg <= year3_reg;
            mon4_reg  <= mon4_next;
        end
        if (en[5])
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
        end
    end

    assign year  = year_reg;
    assign month = month_reg;
    assign day   = day_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ucd_clock_path.sv -----
// Time-of-day pipeline: seconds within the day to hour, minute and second.
`default_nettype none

module ucd_clock_path
(
    input  wire logic                clk,
    input  wire ucd_pkg::stage_vec_t en,
    input  wire logic [31:0]         secs,
    input  wire ucd_pkg::day_num_t   day_num,
    output logic [4:0]               hour,
    output logic [5:0]               minute,
    output logic [5:0]               second
);

    logic [16:0] tod1_reg, tod1_next;
    logic [16:0] tod2_reg;
    logic [4:0]  hour2_reg, hour2_next;
    logic [4:0]  hour3_reg;
    logic [11:0] rem3_reg, rem3_next;
    logic [4:0]  hour4_reg;
    logic [11:0] rem4_reg;
    logic [5:0]  min4_reg, min4_next;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg, second_next;

    logic [24:0] day_odd_prod;
    logic [24:0] day_odd_rem;
    logic [25:0] hour_prod;
    logic [16:0] hour_secs;
    logic [16:0] rem_wide;
    logic [20:0] min_prod;
    logic [11:0] min_secs;
    logic [11:0] sec_wide;

    // remainder of the odd factor of 86400, low seven bits pass straight
    assign day_odd_prod = {9'd0, day_num} * {15'd0, ucd_pkg::DAY_ODD_FACTOR};
    assign day_odd_rem  = secs[31:ucd_pkg::DAY_POW2_SHIFT] - day_odd_prod;
    assign tod1_next    = {day_odd_rem[9:0], secs[ucd_pkg::DAY_POW2_SHIFT-1:0]};

    // hour: (tod >> 4) / 225 by exact reciprocal
    assign hour_prod  = {13'd0, tod1_reg[16:4]} * 26'd4661;
    assign hour2_next = hour_prod[24:20];

    assign hour_secs = {12'd0, hour2_reg} * 17'd3600;
    assign rem_wide  = tod2_reg - hour_secs;
    assign rem3_next = rem_wide[11:0];

    // minute: (rem >> 2) / 15 by exact reciprocal
    assign min_prod  = {11'd0, rem3_reg[11:2]} * 21'd1093;
    assign min4_next = min_prod[19:14];

    assign min_secs    = {6'd0, min4_reg} * 12'd60;
    assign sec_wide    = rem4_reg - min_secs;
    assign second_next = sec_wide[5:0];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            tod1_reg <= tod1_next;
        end
        if (en[2])
        begin
            tod2_reg  <= tod1_reg;
            hour2_reg <= hour2_next;
        end
        if (en[3])
        begin
            hour3_reg <= hour2_reg;
            rem3_reg  <= rem3_next;
        end
        if (en[4])
        begin
            hour4_reg <= hour3_reg;
            rem4_reg  <= rem3_reg;
            min4_reg  <= min4_next;
        end
        if (en[5])
        begin
            hour_reg   <= hour4_reg;
            minute_reg <= min4_reg;
            second_reg <= second_next;
        end
    end

    assign hour   = hour_reg;
    assign minute = minute_reg;
    assign second = second_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/unix_seconds_to_civil_date_top.sv -----
// Throughput: one request per cycle while the output is not stalled.
// There are six register stages, at most one multiply per path in each.
// Each stage holds only while it is full and the stage after it is stalled,
// so empty stages keep accepting while a finished result waits.
// Reset clears the stage valid bits only; the datapath registers are not reset.
`default_nettype none

module unix_seconds_to_civil_date_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // unix_seconds[31:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata    // year_out[11:0], month_out[15:12], day_out[20:16],
                                             // hour_out[25:21], minute_out[31:26],
                                             // second_out[37:32], zero[39:38]
);

    ucd_pkg::stage_vec_t valid_reg, valid_next;
    ucd_pkg::stage_vec_t en;

    ucd_pkg::day_num_t day0_reg;
    logic [31:0]       secs0_reg;
    logic [50:0]       day_prod;

    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;

    // a stage may load when it is empty or its contents move on
    always_comb
    begin
        en[ucd_pkg::NUM_STAGES-1] = !valid_reg[ucd_pkg::NUM_STAGES-1] || m_axis_tready;
        for (int k = ucd_pkg::NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        valid_next[0] = en[0] ? s_axis_tvalid : valid_reg[0];
        for (int k = 1; k < ucd_pkg::NUM_STAGES; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // whole days: (secs >> 7) / 675 as an exact reciprocal multiply
    assign day_prod = {26'd0, s_axis_tdata[31:ucd_pkg::DAY_POW2_SHIFT]}
                    * {25'd0, ucd_pkg::DAY_RECIP};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            day0_reg  <= day_prod[ucd_pkg::DAY_RECIP_SHR+15:ucd_pkg::DAY_RECIP_SHR];
            secs0_reg <= s_axis_tdata;
        end
    end

    ucd_date_path u_date
    (
        .clk     (clk),
        .en      (en),
        .day_num (day0_reg),
        .year    (year),
        .month   (month),
        .day     (day)
    );

    ucd_clock_path u_clock
    (
        .clk     (clk),
        .en      (en),
        .secs    (secs0_reg),
        .day_num (day0_reg),
        .hour    (hour),
        .minute  (minute),
        .second  (second)
    );

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = valid_reg[ucd_pkg::NUM_STAGES-1];
    assign m_axis_tdata  = {2'b00, second, minute, hour, day, month, year};

endmodule

`default_nettype wire

// ----- test/civil_date_checker.sv -----
// Checker that predicts each civil date from the accepted timestamps and compares results.
`timescale 1ns / 100ps

module civil_date_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // unix_seconds[31:0]
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata,   // year, month, day, hour, minute, second, zero pad
    output int unsigned      date_errors,
    output int unsigned      dates_outstanding
);

    localparam longint unsigned SECS_PER_DAY  = 64'd86400;
    localparam longint unsigned DAYS_YEAR     = 64'd365;
    localparam longint unsigned DAYS_4Y       = 64'd1461;
    localparam longint unsigned DAYS_100Y     = 64'd36524;
    localparam longint unsigned DAYS_400Y     = 64'd146097;
    localparam longint unsigned MARCH_EPOCH   = 64'd719468;
    localparam longint unsigned FIVE_MONTHS   = 64'd153;
    localparam longint unsigned SECS_PER_HOUR = 64'd3600;

    typedef struct packed {
        logic [1:0]  pad;
        logic [5:0]  sec;
        logic [5:0]  mins;
        logic [4:0]  hr;
        logic [4:0]  mday;
        logic [3:0]  mon;
        logic [11:0] yr;
    } civil_date_t;

    typedef struct {
        logic [31:0] secs;
        civil_date_t date;
    } pending_date_t;

    pending_date_t expected_dates [$];
    int unsigned   error_tally = 0;

    assign date_errors = error_tally;

    function automatic civil_date_t seconds_to_civil(input logic [31:0] secs);
        longint unsigned days;
        longint unsigned tod;
        longint unsigned cyc;
        longint unsigned yr;
        longint unsigned mon;
        longint unsigned dom;
        civil_date_t     d;
        begin
            days = MARCH_EPOCH + longint'(secs) / SECS_PER_DAY;
            tod  = longint'(secs) % SECS_PER_DAY;

            // strip whole centuries, then whole years, of the March-based calendar
            cyc  = (4 * (days + DAYS_100Y + 1)) / DAYS_400Y - 1;
            yr   = 100 * cyc;
            days = days - (DAYS_100Y * cyc + cyc / 4);
            cyc  = (4 * (days + DAYS_YEAR + 1)) / DAYS_4Y - 1;
            yr   = yr + cyc;
            days = days - (DAYS_YEAR * cyc + cyc / 4);

            mon = (5 * days + 2) / FIVE_MONTHS;
            dom = days - (mon * FIVE_MONTHS + 2) / 5 + 1;
            mon = mon + 3;
            // January and February belong to the next civil year
            if (mon > 12)
            begin
                mon = mon - 12;
                yr  = yr + 1;
            end

            d.yr   = yr[11:0];
            d.mon  = mon[3:0];
            d.mday = dom[4:0];
            d.hr   = 5'(tod / SECS_PER_HOUR);
            d.mins = 6'((tod % SECS_PER_HOUR) / 60);
            d.sec  = 6'(tod % 60);
            d.pad  = 2'b00;
            return d;
        end
    endfunction

    task automatic report_date_error(input string what, input logic [31:0] secs,
                                     input int unsigned got, input int unsigned want);
        begin
            $display("%0t date check error: %s for %0d seconds, got %0d expected %0d",
                     $time, what, secs, got, want);
            error_tally++;
        end
    endtask

    task automatic compare_field(input string what, input logic [31:0] secs,
                                 input int unsigned got, input int unsigned want);
        begin
            if (got != want)
                report_date_error(what, secs, got, want);
        end
    endtask

    always @(posedge clk)
    begin
        pending_date_t want;
        civil_date_t   got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_dates.size() == 0)
                    report_date_error("unexpected result", 32'd0, 32'(got), 0);
                else
                begin
                    want = expected_dates.pop_front();
                    compare_field("year", want.secs, got.yr, want.date.yr);
                    compare_field("month", want.secs, got.mon, want.date.mon);
                    compare_field("day", want.secs, got.mday, want.date.mday);
                    compare_field("hour", want.secs, got.hr, want.date.hr);
                    compare_field("minute", want.secs, got.mins, want.date.mins);
                    compare_field("second", want.secs, got.sec, want.date.sec);
                    compare_field("pad bits", want.secs, got.pad, want.date.pad);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                want.secs = s_axis_tdata;
                want.date = seconds_to_civil(s_axis_tdata);
                expected_dates.push_back(want);
            end
        end
        dates_outstanding <= expected_dates.size();
    end

endmodule

// ----- test/tb_unix_seconds_to_civil_date_top.sv -----
// Stimulus and verdict for the Unix seconds to civil date converter.
`timescale 1ns / 100ps

module tb_unix_seconds_to_civil_date_top;

    localparam int unsigned RANDOM_REQUESTS = 2000;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned IDLE_PERCENT    = 31;
    localparam int unsigned MAX_DAY         = 49710;

    localparam logic [31:0] CORNER_SECS [25] = '{
        32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd86399, 32'd86400,
        32'd5097599, 32'd5097600, 32'd31535999, 32'd31536000,
        32'd68169600, 32'd68255999, 32'd946684799, 32'd946684800,
        32'd951782400, 32'd2147483647, 32'd2147483648,
        32'd4107542399, 32'd4107542400, 32'd4291660800,
        32'h55555555, 32'hAAAAAAAA, 32'hFFFFFFFE, 32'hFFFFFFFF
    };

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = 32'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        steady_flow   = 1'b0;
    int unsigned date_errors;
    int unsigned dates_outstanding;
    int unsigned cycle_count   = 0;

    unix_seconds_to_civil_date_top u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    civil_date_checker u_checker
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .s_axis_tdata      (s_axis_tdata),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .date_errors       (date_errors),
        .dates_outstanding (dates_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // stall the result side at random, except during the steady stretch
    always @(posedge clk)
    begin
        m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_request(input logic [31:0] secs);
        begin
            if (!steady_flow)
            begin
                while ($urandom_range(0, 99) < IDLE_PERCENT)
                begin
                    s_axis_tvalid <= 1'b0;
                    @(posedge clk);
                end
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= secs;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
        end
    endtask

    task automatic wait_for_dates;
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while (dates_outstanding != 0)
                @(posedge clk);
        end
    endtask

    function automatic logic [31:0] random_seconds();
        longint unsigned day;
        longint unsigned offset;
        longint unsigned secs;
        begin
            day = $urandom_range(0, MAX_DAY);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: return $urandom;
                4, 5:
                begin
                    // land on a midnight, one second after it, or one or two seconds before it
                    case ($urandom_range(0, 3))
                        0:       offset = 0;
                        1:       offset = 1;
                        2:       offset = 86399;
                        default: offset = 86398;
                    endcase
                end
                6, 7:
                begin
                    if ($urandom_range(0, 1) == 0)
                        return $urandom_range(0, 99999);
                    return 32'hFFFFFFFF - $urandom_range(0, 99999);
                end
                default:
                begin
                    offset = $urandom_range(0, 23) * 3600
                           + ($urandom_range(0, 1) ? 59 * 60 : $urandom_range(0, 59) * 60)
                           + ($urandom_range(0, 1) ? 59 : $urandom_range(0, 59));
                end
            endcase
            secs = day * 86400 + offset;
            if (secs > 64'hFFFFFFFF)
                return $urandom;
            return secs[31:0];
        end
    endfunction

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (CORNER_SECS[i])
            send_request(CORNER_SECS[i]);

        for (int unsigned i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i == 700)
                wait_for_dates();
            if (i == 1000)
                steady_flow <= 1'b1;
            if (i == 1300)
                steady_flow <= 1'b0;
            send_request(random_seconds());
        end

        wait_for_dates();
        repeat (ucd_pkg::NUM_STAGES + 4) @(posedge clk);

        if (date_errors == 0 && dates_outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/ucd_pkg.sv
hw/rtl/ucd_date_path.sv
hw/rtl/ucd_clock_path.sv
hw/rtl/unix_seconds_to_civil_date_top.sv
test/civil_date_checker.sv
test/tb_unix_seconds_to_civil_date_top.sv
